// ----- design/vfpl_pkg.sv -----
// Shared types, constants and tables of the velocity low-pass estimator.
`timescale 1ns / 1ps

package vfpl_pkg;

  localparam int AXES       = 3;
  localparam int AX_W       = 2;
  localparam int DT_W       = 20;
  localparam int CUT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int N_W        = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd2;

  localparam logic [DT_W-1:0]  DT_MIN_RESET = 20'd10;
  localparam logic [DT_W-1:0]  DT_MAX_RESET = 20'd100000;
  localparam logic [CUT_W-1:0] CUTOFF_RESET = 17'd1000;

  // Two pi times 1e-9 in Q48.
  localparam logic [20:0]    GAIN_K       = 21'd1768559;
  localparam logic [19:0]    VEL_SCALE    = 20'd1000000;
  localparam logic [30:0]    ONE_Q30      = 31'h4000_0000;
  localparam logic [N_W-1:0] TAYLOR_TERMS = 4'd12;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_REARM, OP_G_MUL0, OP_G_MUL1, OP_G_MUL2,
    OP_T_MUL, OP_T_RCP, OP_T_FIX, OP_E_INIT, OP_SQ, OP_ALPHA,
    OP_V_MUL, OP_V_DIV, OP_V_SAT, OP_F_MUL, OP_F_UPD, OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [AX_W-1:0] axis;
    logic [N_W-1:0]  n;
  } dp_cmd_t;

  typedef struct packed {
    logic rearm;
    logic big;
  } dp_status_t;

  // Floor of 2^32 / n for the Taylor term divisors.
  function automatic logic [32:0] recip(input logic [N_W-1:0] n);
    logic [32:0] res;
    case (n)
      4'd1:    res = 33'h1_0000_0000;
      4'd2:    res = 33'd2147483648;
      4'd3:    res = 33'd1431655765;
      4'd4:    res = 33'd1073741824;
      4'd5:    res = 33'd858993459;
      4'd6:    res = 33'd715827882;
      4'd7:    res = 33'd613566756;
      4'd8:    res = 33'd536870912;
      4'd9:    res = 33'd477218588;
      4'd10:   res = 33'd429496729;
      4'd11:   res = 33'd390451572;
      4'd12:   res = 33'd357913941;
      default: res = 33'd0;
    endcase
    return res;
  endfunction

endpackage

// ----- design/vfpl_sample_if.sv -----
// Handshake channel that carries one position sample item.
`timescale 1ns / 1ps

interface vfpl_sample_if #(parameter int SAMPLE_WIDTH = 32);
  logic                                valid;
  logic                                ready;
  logic signed [SAMPLE_WIDTH-1:0]      pos_x;
  logic signed [SAMPLE_WIDTH-1:0]      pos_y;
  logic signed [SAMPLE_WIDTH-1:0]      pos_z;
  logic                                x_invalid;
  logic                                y_invalid;
  logic                                z_invalid;
  logic [vfpl_pkg::DT_W-1:0]           dt_us;

  modport source (output valid, pos_x, pos_y, pos_z, x_invalid, y_invalid, z_invalid,
                  dt_us, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, x_invalid, y_invalid, z_invalid,
                dt_us, output ready);
endinterface

// ----- design/vfpl_result_if.sv -----
// Handshake channel that carries one filtered velocity item.
`timescale 1ns / 1ps

interface vfpl_result_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] vel_x;
  logic signed [SAMPLE_WIDTH-1:0] vel_y;
  logic signed [SAMPLE_WIDTH-1:0] vel_z;
  logic                           was_reset;

  modport source (output valid, vel_x, vel_y, vel_z, was_reset, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, was_reset, output ready);
endinterface

// ----- design/velocity_from_position_lpf_core.sv -----
// Top level of the velocity-from-position estimator with low-pass smoothing.
//
//   port      dir  flow         content
//   sample    in   valid/ready  pos_x/y/z, x/y/z_invalid, dt_us
//   result    out  valid/ready  vel_x/y/z, was_reset
//   cfg_*     in   write only   dt_min_us, dt_max_us, cutoff_millihertz
//
// A re-arming item goes from the check step straight to the finish step.
// Any other item runs the gain steps, the series and then, for each axis, the
// one-bit-per-cycle divider and the filter update; the series is skipped
// when the gain is large enough.
// Synchronous reset returns the estimator to the unprimed state.
// A new item is taken while the previous result still waits; the block holds
// its finished result until the result register is free.
`timescale 1ns / 1ps

module velocity_from_position_lpf_core #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  vfpl_sample_if.sink                     sample,
  vfpl_result_if.source                   result,
  input  logic                            cfg_wr_en,
  input  logic [vfpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vfpl_pkg::CFG_DATA_W-1:0] cfg_data
);

  vfpl_pkg::dp_cmd_t           cmd;
  vfpl_pkg::dp_status_t        status;
  logic signed [SAMPLE_WIDTH-1:0] pos_in [vfpl_pkg::AXES];
  logic [vfpl_pkg::AXES-1:0]      invalid_in;
  logic signed [SAMPLE_WIDTH-1:0] vel [vfpl_pkg::AXES];
  logic                           was_reset;

  assign pos_in[0]  = sample.pos_x;
  assign pos_in[1]  = sample.pos_y;
  assign pos_in[2]  = sample.pos_z;
  assign invalid_in = {sample.z_invalid, sample.y_invalid, sample.x_invalid};

  vfpl_ctrl #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .cmd          (cmd),
    .status       (status)
  );

  vfpl_datapath #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pos_in     (pos_in),
    .invalid_in (invalid_in),
    .dt_in      (sample.dt_us),
    .cmd        (cmd),
    .status     (status),
    .vel        (vel),
    .was_reset  (was_reset)
  );

  assign result.vel_x     = vel[0];
  assign result.vel_y     = vel[1];
  assign result.vel_z     = vel[2];
  assign result.was_reset = was_reset;

endmodule

// ----- design/vfpl_datapath.sv -----
// Datapath: configuration, estimator state, gain series, divider and filter.
`timescale 1ns / 1ps

module vfpl_datapath #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [vfpl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vfpl_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]        pos_in [vfpl_pkg::AXES],
  input  logic [vfpl_pkg::AXES-1:0]             invalid_in,
  input  logic [vfpl_pkg::DT_W-1:0]             dt_in,
  input  vfpl_pkg::dp_cmd_t                     cmd,
  output vfpl_pkg::dp_status_t                  status,
  output logic signed [SAMPLE_WIDTH-1:0]        vel [vfpl_pkg::AXES],
  output logic                                  was_reset
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int NW = SAMPLE_WIDTH + 20;
  localparam logic signed [W-1:0]   VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+2:0]   YMAX = {3'b000, VMAX};
  localparam logic signed [W+2:0]   YMIN = {3'b111, VMIN};
  localparam logic signed [32:0]    SUM_ONE = {2'b00, vfpl_pkg::ONE_Q30};

  logic [vfpl_pkg::DT_W-1:0]  dt_min;
  logic [vfpl_pkg::DT_W-1:0]  dt_max;
  logic [vfpl_pkg::CUT_W-1:0] cutoff;
  logic                       primed;
  logic                       rearm;
  logic                       big;

  logic signed [W-1:0]        p    [vfpl_pkg::AXES];
  logic signed [W-1:0]        prev [vfpl_pkg::AXES];
  logic signed [W-1:0]        filt [vfpl_pkg::AXES];
  logic [vfpl_pkg::DT_W-1:0]  dt;

  logic [36:0]         p1;
  logic [40:0]         acc;
  logic [29:0]         r;
  logic [30:0]         term;
  logic signed [32:0]  sum;
  logic [29:0]         x;
  logic [29:0]         q0;
  logic [30:0]         e;
  logic [16:0]         alpha;

  logic                neg;
  logic [NW-1:0]       dq;
  logic [vfpl_pkg::DT_W-1:0] rem;
  logic signed [W-1:0] xv;
  logic                cneg;
  logic [W+1:0]        c;

  logic [vfpl_pkg::AX_W-1:0] ax;
  logic [37:0]         hk;
  logic [57:0]         gfull;
  logic [60:0]         tm;
  logic [62:0]         rp;
  logic [33:0]         qn;
  logic [33:0]         rm;
  logic [29:0]         q;
  logic [61:0]         sqp;
  logic [31:0]         ea;
  logic [17:0]         et;
  logic [W:0]          dpd;
  logic [W:0]          dpm;
  logic [W+20:0]       num_full;
  logic [20:0]         rs;
  logic                ge;
  logic [20:0]         rs_sub;
  logic                sat;
  logic signed [W-1:0] vsat;
  logic [W:0]          fd;
  logic [W:0]          fm;
  logic [W+1:0]        hi_prod;
  logic [32:0]         lo_prod;
  logic signed [W+2:0] yext;
  logic signed [W+2:0] cext;
  logic signed [W+2:0] ysum;
  logic signed [W-1:0] ynew;
  logic                rearm_next;

  always_comb begin
    ax         = cmd.axis;
    rearm_next = !primed || (dt_in <= dt_min) || (dt_in > dt_max);

    hk    = {21'b0, p1[36:20]} * {17'b0, vfpl_pkg::GAIN_K};
    gfull = {hk, 20'b0} + {17'b0, acc};
    tm    = {30'b0, term} * {31'b0, r};
    rp    = {33'b0, x} * {30'b0, vfpl_pkg::recip(cmd.n)};
    qn    = {4'b0, q0} * {30'b0, cmd.n};
    rm    = {4'b0, x} - qn;
    q     = (rm >= {30'b0, cmd.n}) ? q0 + 30'd1 : q0;
    sqp   = {31'b0, e} * {31'b0, e};
    ea    = {1'b0, e} + 32'd8192;
    et    = ea[31:14];

    dpd      = {p[ax][W-1], p[ax]} - {prev[ax][W-1], prev[ax]};
    dpm      = dpd[W] ? -dpd : dpd;
    num_full = {20'b0, dpm} * {{(W+1){1'b0}}, vfpl_pkg::VEL_SCALE};

    rs     = {rem, dq[NW-1]};
    ge     = rs >= {1'b0, dt};
    rs_sub = rs - {1'b0, dt};

    sat = |dq[NW-1:W-1];
    if (sat) begin
      vsat = neg ? VMIN : VMAX;
    end else begin
      vsat = neg ? -dq[W-1:0] : dq[W-1:0];
    end

    fd      = {xv[W-1], xv} - {filt[ax][W-1], filt[ax]};
    fm      = fd[W] ? -fd : fd;
    hi_prod = {17'b0, fm[W:16]} * {{(W-15){1'b0}}, alpha};
    lo_prod = {17'b0, fm[15:0]} * {16'b0, alpha};

    yext = {{3{filt[ax][W-1]}}, filt[ax]};
    cext = {1'b0, c};
    ysum = cneg ? yext - cext : yext + cext;
    if (ysum > YMAX) begin
      ynew = VMAX;
    end else if (ysum < YMIN) begin
      ynew = VMIN;
    end else begin
      ynew = ysum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_min <= vfpl_pkg::DT_MIN_RESET;
      dt_max <= vfpl_pkg::DT_MAX_RESET;
      cutoff <= vfpl_pkg::CUTOFF_RESET;
      primed <= 1'b0;
      rearm  <= 1'b0;
      big    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          vfpl_pkg::CFG_DT_MIN: dt_min <= cfg_data[vfpl_pkg::DT_W-1:0];
          vfpl_pkg::CFG_DT_MAX: dt_max <= cfg_data[vfpl_pkg::DT_W-1:0];
          vfpl_pkg::CFG_CUTOFF: cutoff <= cfg_data[vfpl_pkg::CUT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == vfpl_pkg::OP_LOAD) begin
        rearm <= rearm_next;
      end
      if (cmd.op == vfpl_pkg::OP_REARM) begin
        primed <= 1'b1;
      end
      if (cmd.op == vfpl_pkg::OP_G_MUL2) begin
        big <= |gfull[57:52];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vfpl_pkg::OP_LOAD: begin
        for (int i = 0; i < vfpl_pkg::AXES; i++) begin
          p[i] <= invalid_in[i] ? '0 : pos_in[i];
        end
        dt <= dt_in;
      end
      vfpl_pkg::OP_REARM: begin
        for (int i = 0; i < vfpl_pkg::AXES; i++) begin
          prev[i] <= p[i];
          filt[i] <= '0;
        end
      end
      vfpl_pkg::OP_G_MUL0: p1  <= {20'b0, cutoff} * {17'b0, dt};
      vfpl_pkg::OP_G_MUL1: acc <= {21'b0, p1[19:0]} * {20'b0, vfpl_pkg::GAIN_K};
      vfpl_pkg::OP_G_MUL2: begin
        r    <= gfull[51:22];
        term <= vfpl_pkg::ONE_Q30;
        sum  <= SUM_ONE;
      end
      vfpl_pkg::OP_T_MUL: x  <= tm[59:30];
      vfpl_pkg::OP_T_RCP: q0 <= rp[61:32];
      vfpl_pkg::OP_T_FIX: begin
        term <= {1'b0, q};
        sum  <= cmd.n[0] ? sum - {3'b0, q} : sum + {3'b0, q};
      end
      vfpl_pkg::OP_E_INIT: begin
        if (big || sum[32]) begin
          e <= '0;
        end else if (sum > SUM_ONE) begin
          e <= vfpl_pkg::ONE_Q30;
        end else begin
          e <= sum[30:0];
        end
      end
      vfpl_pkg::OP_SQ:    e     <= sqp[60:30];
      vfpl_pkg::OP_ALPHA: alpha <= 17'(18'd65536 - et);
      vfpl_pkg::OP_V_MUL: begin
        neg <= dpd[W];
        dq  <= num_full[NW-1:0];
        rem <= '0;
      end
      vfpl_pkg::OP_V_DIV: begin
        rem <= ge ? rs_sub[vfpl_pkg::DT_W-1:0] : rs[vfpl_pkg::DT_W-1:0];
        dq  <= {dq[NW-2:0], ge};
      end
      vfpl_pkg::OP_V_SAT: xv <= vsat;
      vfpl_pkg::OP_F_MUL: begin
        cneg <= fd[W];
        c    <= hi_prod + {{(W-15){1'b0}}, lo_prod[32:16]};
      end
      vfpl_pkg::OP_F_UPD: begin
        filt[ax] <= ynew;
        prev[ax] <= p[ax];
      end
      vfpl_pkg::OP_PUBLISH: begin
        for (int i = 0; i < vfpl_pkg::AXES; i++) begin
          vel[i] <= filt[i];
        end
        was_reset <= rearm;
      end
      default: ;
    endcase
  end

  assign status.rearm = rearm;
  assign status.big   = big;

endmodule

// ----- design/vfpl_ctrl.sv -----
// Controller: sequences the datapath through gain, division and filter steps.
`timescale 1ns / 1ps

module vfpl_ctrl #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic                 result_ready,
  output logic                 result_valid,
  output vfpl_pkg::dp_cmd_t    cmd,
  input  vfpl_pkg::dp_status_t status
);

  localparam int NW    = SAMPLE_WIDTH + 20;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);
  localparam logic [vfpl_pkg::AX_W-1:0] AX_LAST = vfpl_pkg::AX_W'(vfpl_pkg::AXES - 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_GM1    = 16'h0004,
    S_GM2    = 16'h0008,
    S_TMUL   = 16'h0010,
    S_TRCP   = 16'h0020,
    S_TFIX   = 16'h0040,
    S_EINIT  = 16'h0080,
    S_SQ     = 16'h0100,
    S_ALPHA  = 16'h0200,
    S_VMUL   = 16'h0400,
    S_VDIV   = 16'h0800,
    S_VSAT   = 16'h1000,
    S_FMUL   = 16'h2000,
    S_FUPD   = 16'h4000,
    S_FINISH = 16'h8000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [vfpl_pkg::N_W-1:0]  n;
  logic [1:0]                sq;
  logic [vfpl_pkg::AX_W-1:0] axis;
  logic [CNT_W-1:0]          cnt;
  vfpl_pkg::dp_op_t          op;
  logic                      publish;

  assign sample_ready = (state == S_IDLE);
  assign publish      = (state == S_FINISH) && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    op         = vfpl_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          op         = vfpl_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.rearm) begin
          op         = vfpl_pkg::OP_REARM;
          state_next = S_FINISH;
        end else begin
          op         = vfpl_pkg::OP_G_MUL0;
          state_next = S_GM1;
        end
      end
      S_GM1: begin
        op         = vfpl_pkg::OP_G_MUL1;
        state_next = S_GM2;
      end
      S_GM2: begin
        op         = vfpl_pkg::OP_G_MUL2;
        state_next = S_TMUL;
      end
      S_TMUL: begin
        if (status.big) begin
          state_next = S_EINIT;
        end else begin
          op         = vfpl_pkg::OP_T_MUL;
          state_next = S_TRCP;
        end
      end
      S_TRCP: begin
        op         = vfpl_pkg::OP_T_RCP;
        state_next = S_TFIX;
      end
      S_TFIX: begin
        op         = vfpl_pkg::OP_T_FIX;
        state_next = (n == vfpl_pkg::TAYLOR_TERMS) ? S_EINIT : S_TMUL;
      end
      S_EINIT: begin
        op         = vfpl_pkg::OP_E_INIT;
        state_next = S_SQ;
      end
      S_SQ: begin
        op         = vfpl_pkg::OP_SQ;
        state_next = (sq == 2'd3) ? S_ALPHA : S_SQ;
      end
      S_ALPHA: begin
        op         = vfpl_pkg::OP_ALPHA;
        state_next = S_VMUL;
      end
      S_VMUL: begin
        op         = vfpl_pkg::OP_V_MUL;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        op         = vfpl_pkg::OP_V_DIV;
        state_next = (cnt == CNT_LAST) ? S_VSAT : S_VDIV;
      end
      S_VSAT: begin
        op         = vfpl_pkg::OP_V_SAT;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        op         = vfpl_pkg::OP_F_MUL;
        state_next = S_FUPD;
      end
      S_FUPD: begin
        op         = vfpl_pkg::OP_F_UPD;
        state_next = (axis == AX_LAST) ? S_FINISH : S_VMUL;
      end
      S_FINISH: begin
        if (publish) begin
          op         = vfpl_pkg::OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      n            <= 4'd1;
      sq           <= '0;
      axis         <= '0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == S_GM2) begin
        n <= 4'd1;
      end else if (state == S_TFIX) begin
        n <= n + 4'd1;
      end
      if (state == S_EINIT) begin
        sq <= '0;
      end else if (state == S_SQ) begin
        sq <= sq + 2'd1;
      end
      if (state == S_ALPHA) begin
        axis <= '0;
      end else if (state == S_FUPD) begin
        axis <= axis + 1'b1;
      end
      if (state == S_VMUL) begin
        cnt <= '0;
      end else if (state == S_VDIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign cmd.op   = op;
  assign cmd.axis = axis;
  assign cmd.n    = n;

`ifndef ASSERT_OFF
  a_publish_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finish step");
  a_accept_then_check: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == S_CHECK)
    else $error("accepted item not followed by the check step");
  a_term_index_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TFIX |-> (n >= 4'd1 && n <= vfpl_pkg::TAYLOR_TERMS))
    else $error("series term index out of range");
  a_div_count_range: assert property (@(posedge clk) disable iff (rst)
    state == S_VDIV |-> cnt <= CNT_LAST)
    else $error("divider step count overran");
`endif

endmodule

// ----- verif/tb_velocity_from_position_lpf_core.sv -----
// Self-checking testbench for the velocity-from-position low-pass estimator.
`timescale 1ns / 1ps

module tb_velocity_from_position_lpf_core;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic               xi, yi, zi;
    logic [19:0]        dt;
  } sample_t;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic               rs;
    logic               typed;
  } vel_t;

  localparam logic [vfpl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [vfpl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vfpl_pkg::CFG_DATA_W-1:0] cfg_data;

  vfpl_sample_if #(32) sample ();
  vfpl_result_if #(32) result ();

  velocity_from_position_lpf_core #(.SAMPLE_WIDTH(32)) uut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [19:0] m_dt_min, m_dt_max;
  logic [16:0] m_cutoff;
  longint      m_prev[3];
  longint      m_filt[3];
  bit          m_primed;

  vel_t    expected_vel[$];
  sample_t directed[$];
  vel_t    directed_exp[$];
  int      errors;
  int      idle_cycles;
  bit      hold_result;
  bit      rx_random;

  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic longint gain_alpha(input logic [19:0] dt);
    logic [63:0] a, r, term;
    longint      sum, e, al;
    a = (64'(m_cutoff) * 64'(dt) * 64'd1768559) >> 18;
    if (a >= (64'd16 << 30)) begin
      e = 0;
    end else begin
      r = a >> 4;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * r) >> 30) / 64'(n);
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
      e = sum;
      for (int k = 0; k < 4; k++) e = longint'((64'(e) * 64'(e)) >> 30);
    end
    al = 65536 - ((e + 8192) >>> 14);
    if (al < 0) al = 0;
    if (al > 65536) al = 65536;
    return al;
  endfunction

  function automatic longint diff_velocity(input longint dp, input logic [19:0] dt);
    logic [63:0] m, q, rm, v;
    m = dp < 0 ? 64'(-dp) : 64'(dp);
    q = m / 64'(dt);
    rm = m % 64'(dt);
    if (q >= (64'd1 << 43)) v = 64'd1 << 31;
    else v = q * 64'd1000000 + (rm * 64'd1000000) / 64'(dt);
    if (v > (64'd1 << 31)) v = 64'd1 << 31;
    return clamp32(dp < 0 ? -longint'(v) : longint'(v));
  endfunction

  function automatic longint smooth(input longint y, input longint x, input longint al);
    longint      d;
    logic [63:0] m, c;
    d = x - y;
    m = d < 0 ? 64'(-d) : 64'(d);
    c = (m >> 16) * 64'(al) + (((m & 64'hFFFF) * 64'(al)) >> 16);
    return clamp32(d < 0 ? y - longint'(c) : y + longint'(c));
  endfunction

  function automatic vel_t predict_velocity(input sample_t s);
    vel_t   o;
    longint p[3];
    longint al;
    p[0] = s.xi ? 0 : longint'(s.px);
    p[1] = s.yi ? 0 : longint'(s.py);
    p[2] = s.zi ? 0 : longint'(s.pz);
    o.typed = 1'b0;
    if (!m_primed || s.dt <= m_dt_min || s.dt > m_dt_max) begin
      for (int i = 0; i < 3; i++) begin
        m_prev[i] = p[i];
        m_filt[i] = 0;
      end
      m_primed = 1'b1;
      o.rs = 1'b1;
    end else begin
      al = gain_alpha(s.dt);
      for (int i = 0; i < 3; i++) begin
        m_filt[i] = smooth(m_filt[i], diff_velocity(p[i] - m_prev[i], s.dt), al);
        m_prev[i] = p[i];
      end
      o.rs = 1'b0;
    end
    o.vx = m_filt[0][31:0];
    o.vy = m_filt[1][31:0];
    o.vz = m_filt[2][31:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [vfpl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vfpl_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      vfpl_pkg::CFG_DT_MIN: m_dt_min = val;
      vfpl_pkg::CFG_DT_MAX: m_dt_max = val;
      vfpl_pkg::CFG_CUTOFF: m_cutoff = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input vel_t typed, input int gap);
    vel_t e;
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid     <= 1'b1;
    sample.pos_x     <= s.px;
    sample.pos_y     <= s.py;
    sample.pos_z     <= s.pz;
    sample.x_invalid <= s.xi;
    sample.y_invalid <= s.yi;
    sample.z_invalid <= s.zi;
    sample.dt_us     <= s.dt;
    do @(posedge clk); while (!sample.ready);
    e = predict_velocity(s);
    if (typed.typed) begin
      if (typed.rs !== e.rs || typed.vx !== e.vx || typed.vy !== e.vy ||
          typed.vz !== e.vz)
        report_mismatch("typed row vs predictor", e.vx, typed.vx);
    end
    expected_vel.push_back(e);
  endtask

  task automatic drain;
    sample.valid <= 1'b0;
    while (expected_vel.size() != 0) @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(input int mode);
    sample_t s;
    s.px = $urandom;
    s.py = $urandom;
    s.pz = $urandom;
    if (mode == 0) begin
      s.px = $signed($urandom_range(0, 400000)) - 200000;
      s.py = $signed($urandom_range(0, 400000)) - 200000;
      s.pz = $signed($urandom_range(0, 4000)) - 2000;
    end
    s.xi = ($urandom_range(0, 9) == 0);
    s.yi = ($urandom_range(0, 9) == 0);
    s.zi = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0:       s.dt = 20'($urandom);
      1:       s.dt = 20'($urandom_range(0, 20));
      default: s.dt = 20'($urandom_range(11, 30000));
    endcase
    return s;
  endfunction

  function automatic sample_t mk(input longint x, input longint y, input longint z,
                                 input bit xi, input bit yi, input bit zi, input int dt);
    sample_t s;
    s.px = x[31:0];
    s.py = y[31:0];
    s.pz = z[31:0];
    s.xi = xi;
    s.yi = yi;
    s.zi = zi;
    s.dt = dt[19:0];
    return s;
  endfunction

  function automatic vel_t rs_row();
    vel_t v;
    v.vx = 0;
    v.vy = 0;
    v.vz = 0;
    v.rs = 1'b1;
    v.typed = 1'b1;
    return v;
  endfunction

  function automatic vel_t no_row();
    vel_t v;
    v = rs_row();
    v.typed = 1'b0;
    return v;
  endfunction

  always @(posedge clk) begin
    vel_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_vel.size() == 0) begin
        report_mismatch("result with nothing expected", result.vel_x, 0);
      end else begin
        e = expected_vel.pop_front();
        if (result.vel_x !== e.vx) report_mismatch("vel_x", result.vel_x, e.vx);
        if (result.vel_y !== e.vy) report_mismatch("vel_y", result.vel_y, e.vy);
        if (result.vel_z !== e.vz) report_mismatch("vel_z", result.vel_z, e.vz);
        if (result.was_reset !== e.rs)
          report_mismatch("was_reset", result.was_reset, e.rs);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int wait_n;
    result.ready = 1'b0;
    forever begin
      if (hold_result) begin
        result.ready <= 1'b0;
        @(posedge clk);
      end else begin
        wait_n = rx_random ? $urandom_range(0, 6) : 0;
        if (wait_n > 0) begin
          result.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        result.ready <= 1'b1;
        do @(posedge clk); while (!result.valid && !hold_result);
      end
    end
  end

  initial begin
    errors = 0;
    hold_result = 1'b0;
    rx_random = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = vfpl_pkg::CFG_DT_MIN;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.pos_x = '0;
    sample.pos_y = '0;
    sample.pos_z = '0;
    sample.x_invalid = 1'b0;
    sample.y_invalid = 1'b0;
    sample.z_invalid = 1'b0;
    sample.dt_us = '0;
    m_dt_min = vfpl_pkg::DT_MIN_RESET;
    m_dt_max = vfpl_pkg::DT_MAX_RESET;
    m_cutoff = vfpl_pkg::CUTOFF_RESET;
    m_primed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m_prev[i] = 0;
      m_filt[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk(65536, -65536, 0, 0, 0, 0, 1000));
    directed_exp.push_back(rs_row());
    directed.push_back(mk(131072, -131072, 7, 0, 0, 0, 1000));
    directed_exp.push_back(no_row());
    directed.push_back(mk(S_MAX, S_MIN, -1, 0, 0, 0, 11));
    directed_exp.push_back(no_row());
    directed.push_back(mk(S_MIN, S_MAX, 0, 0, 0, 0, 11));
    directed_exp.push_back(no_row());
    directed.push_back(mk(5, 5, 5, 1, 1, 1, 500));
    directed_exp.push_back(no_row());
    directed.push_back(mk(100, 200, 300, 0, 0, 0, 10));
    directed_exp.push_back(rs_row());
    directed.push_back(mk(100, 200, 300, 0, 0, 0, 100001));
    directed_exp.push_back(rs_row());
    directed.push_back(mk(1000, 2000, 3000, 1, 0, 1, 100000));
    directed_exp.push_back(no_row());
    directed.push_back(mk(-1, -1, -1, 0, 0, 0, 0));
    directed_exp.push_back(rs_row());
    directed.push_back(mk(-1, -1, -1, 0, 0, 0, 1048575));
    directed_exp.push_back(rs_row());
    directed.push_back(mk(40000, -40000, 12345, 0, 0, 0, 2000));
    directed_exp.push_back(no_row());
    for (int i = 0; i < directed.size(); i++)
      send_sample(directed[i], directed_exp[i], 0);
    drain();

    write_reg(vfpl_pkg::CFG_CUTOFF, 20'd0);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0), rs_row(), 0);
    send_sample(mk(9999, 9999, 9999, 0, 0, 0, 5000), no_row(), 0);
    drain();
    write_reg(vfpl_pkg::CFG_CUTOFF, 20'd100000);
    write_reg(vfpl_pkg::CFG_DT_MIN, 20'd0);
    write_reg(vfpl_pkg::CFG_DT_MAX, 20'hFFFFF);
    write_reg(CFG_UNUSED, 20'hABCDE);
    send_sample(mk(0, 0, 0, 0, 0, 0, 1), no_row(), 0);
    send_sample(mk(S_MAX, S_MIN, 1, 0, 0, 0, 1), no_row(), 0);
    send_sample(mk(S_MIN, S_MAX, 1, 0, 0, 0, 1048575), no_row(), 0);
    drain();

    rx_random = 1'b1;
    hold_result = 1'b1;
    fork
      begin
        repeat (800) @(posedge clk);
        hold_result = 1'b0;
      end
      for (int i = 0; i < 4; i++)
        send_sample(rand_sample(0), no_row(), 0);
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(vfpl_pkg::CFG_DT_MIN, 20'd10);
          write_reg(vfpl_pkg::CFG_DT_MAX, 20'd100000);
          write_reg(vfpl_pkg::CFG_CUTOFF, 20'd1000);
        end
        1: write_reg(vfpl_pkg::CFG_CUTOFF, 20'($urandom_range(1, 100000)));
        2: begin
          write_reg(vfpl_pkg::CFG_DT_MIN, 20'($urandom_range(0, 50)));
          write_reg(vfpl_pkg::CFG_DT_MAX, 20'($urandom_range(1000, 1048575)));
        end
        default: write_reg(vfpl_pkg::CFG_CUTOFF, 20'd100000);
      endcase
      for (int i = 0; i < 110; i++)
        send_sample(rand_sample($urandom_range(0, 3) == 0), no_row(),
                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
